@@ sv/plsm_pkg.sv @@
// Shared types, constants and microcode table for the PID line steering mixer.
// No dependencies. Used by plsm_sequencer, plsm_datapath and the top level.
package plsm_pkg;

    localparam int SUM_WIDTH_DEF = 24;

    // configuration register indexes
    localparam logic [7:0] REG_WHITE  = 8'd0;
    localparam logic [7:0] REG_TARGET = 8'd1;
    localparam logic [7:0] REG_POWER  = 8'd2;
    localparam logic [7:0] REG_PGAIN  = 8'd3;
    localparam logic [7:0] REG_IGAIN  = 8'd4;
    localparam logic [7:0] REG_DGAIN  = 8'd5;

    // configuration reset values
    localparam logic [7:0]        WHITE_RST  = 8'd100;
    localparam logic [7:0]        TARGET_RST = 8'd40;
    localparam logic signed [7:0] POWER_RST  = 8'sd60;
    localparam logic [15:0]       PGAIN_RST  = 16'd640;
    localparam logic [15:0]       IGAIN_RST  = 16'd655;
    localparam logic [15:0]       DGAIN_RST  = 16'd1280;

    localparam int STEER_LIMIT = 80;
    localparam int POWER_LIMIT = 100;
    localparam int MIN_DRIVE   = 5;
    // x / 100 == (x * 5243) >> 19 for 0 <= x <= 10000
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd9;

    typedef struct packed {
        logic [7:0]        white;
        logic [7:0]        target;
        logic signed [7:0] base_power;
        logic [15:0]       p_gain;
        logic [15:0]       i_gain;
        logic [15:0]       d_gain;
    } cfg_t;

    typedef enum logic [2:0] {
        MA_PGAIN, MA_DGAIN, MA_IGAIN, MA_POWER, MA_RECIP
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_ERR, MB_DIFF, MB_SUMLO, MB_SUMHI, MB_FACTOR, MB_ABS
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_NONE, SH_BYTE, SH_HALF
    } acc_sh_t;

    typedef enum logic [1:0] {
        COND_NONE, COND_NO_IN, COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        logic              in_rdy;
        logic              mul_en;
        mul_a_t            mul_a;
        mul_b_t            mul_b;
        acc_op_t           acc_op;
        acc_sh_t           acc_sh;
        logic              upd_sum;
        logic              ld_steer;
        logic              ld_sign;
        logic              ld_out;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucw_t;

    typedef struct packed {
        logic in_fire;
        logic out_full;
    } seq_stat_t;

    function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
        ucw_t w;
        w = '0;
        w.mul_a  = MA_PGAIN;
        w.mul_b  = MB_ERR;
        w.acc_op = ACC_HOLD;
        w.acc_sh = SH_NONE;
        w.cond   = COND_NONE;
        unique case (step)
            4'd0:
            begin
                w.in_rdy = 1'b1;
                w.cond   = COND_NO_IN;
                w.target = STEP_IDLE;
            end
            4'd1:
            begin
                w.upd_sum = 1'b1;
                w.mul_en  = 1'b1;
                w.mul_a   = MA_PGAIN;
                w.mul_b   = MB_ERR;
            end
            4'd2:
            begin
                w.acc_op = ACC_LOAD;
                w.acc_sh = SH_BYTE;
                w.mul_en = 1'b1;
                w.mul_a  = MA_DGAIN;
                w.mul_b  = MB_DIFF;
            end
            4'd3:
            begin
                w.acc_op = ACC_ADD;
                w.acc_sh = SH_BYTE;
                w.mul_en = 1'b1;
                w.mul_a  = MA_IGAIN;
                w.mul_b  = MB_SUMLO;
            end
            4'd4:
            begin
                w.acc_op = ACC_ADD;
                w.acc_sh = SH_NONE;
                w.mul_en = 1'b1;
                w.mul_a  = MA_IGAIN;
                w.mul_b  = MB_SUMHI;
            end
            4'd5:
            begin
                w.acc_op = ACC_ADD;
                w.acc_sh = SH_HALF;
            end
            4'd6:
            begin
                w.ld_steer = 1'b1;
            end
            4'd7:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_POWER;
                w.mul_b  = MB_FACTOR;
            end
            4'd8:
            begin
                w.ld_sign = 1'b1;
                w.mul_en  = 1'b1;
                w.mul_a   = MA_RECIP;
                w.mul_b   = MB_ABS;
            end
            4'd9:
            begin
                w.ld_out = 1'b1;
                w.cond   = COND_OUT_FULL;
                w.target = STEP_OUT;
            end
            default:
            begin
                w.cond   = COND_NONE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ sv/plsm_sequencer.sv @@
// Step counter and microcode fetch for the PID line steering mixer.
// Depends on plsm_pkg (control word type and the microcode table).
module plsm_sequencer
    import plsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output ucw_t      cw
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              jump;

    assign cw = ucode(step_reg);

    always_comb
    begin
        unique case (cw.cond)
            COND_NO_IN:    jump = !stat.in_fire;
            COND_OUT_FULL: jump = stat.out_full;
            default:       jump = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (jump)
            step_next = cw.target;
        else if (step_reg == STEP_LAST)
            step_next = STEP_IDLE;
        else
            step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

@@ sv/plsm_datapath.sv @@
// Datapath of the PID line steering mixer: error/sum state, shared multiplier,
// accumulator, steering scale and output register. Depends on plsm_pkg.
module plsm_datapath
    import plsm_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ucw_t        cw,
    input  cfg_t        cfg,
    input  logic        in_fire,
    input  logic [7:0]  sample,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [23:0] out_data,   // steer_value, left_drive, right_drive
    output logic        out_full
);

    localparam int LO_W  = SUM_WIDTH / 2;
    localparam int HI_W  = SUM_WIDTH - LO_W;
    localparam int MA_W  = 17;
    localparam int MB_W  = (LO_W + 1 > MA_W) ? LO_W + 1 : MA_W;
    localparam int PR_W  = MA_W + MB_W;
    localparam int ACC_W = SUM_WIDTH + 20;
    localparam int Q_W   = ACC_W - 16;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [Q_W-1:0]       Q_HI    = Q_W'(STEER_LIMIT);
    localparam logic signed [Q_W-1:0]       Q_LO    = -Q_HI;
    localparam logic signed [7:0]           PWR_HI  = 8'(POWER_LIMIT);
    localparam logic signed [7:0]           PWR_LO  = -PWR_HI;
    localparam logic signed [7:0]           DRV_MIN = 8'(MIN_DRIVE);

    logic signed [8:0]           err_reg,   err_next;
    logic signed [8:0]           prev_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg,   sum_next;
    logic signed [PR_W-1:0]      prod_reg,  prod_next;
    logic signed [ACC_W-1:0]     acc_reg,   acc_next;
    logic signed [7:0]           steer_reg, steer_next;
    logic                        neg_reg;
    logic                        out_valid_reg;
    logic [23:0]                 out_data_reg;

    logic [7:0]                  capped;
    logic signed [9:0]           diff;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [MA_W-1:0]      a_op;
    logic signed [MB_W-1:0]      b_op;
    logic signed [PR_W-1:0]      prod_neg;
    logic [13:0]                 abs_val;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     addend;
    logic signed [ACC_W-1:0]     acc_bias;
    logic signed [Q_W-1:0]       quot;
    logic signed [7:0]           pid;
    logic signed [7:0]           steer_neg;
    logic [6:0]                  steer_abs;
    logic [6:0]                  factor;
    logic signed [7:0]           power;
    logic [6:0]                  q7;
    logic signed [7:0]           scaled;
    logic signed [7:0]           left_raw,  right_raw;
    logic signed [7:0]           left_drv,  right_drv;
    logic                        out_load;

    // error of this tick
    always_comb
    begin
        capped   = (sample > cfg.white) ? cfg.white : sample;
        err_next = $signed({1'b0, cfg.target}) - $signed({1'b0, capped});
    end

    // trapezoidal sum with saturation
    always_comb
    begin
        diff     = {err_reg[8], err_reg} - {prev_reg[8], prev_reg};
        sum_wide = {sum_reg[SUM_WIDTH-1], sum_reg}
                 + {{(SUM_WIDTH-8){err_reg[8]}}, err_reg}
                 + {{(SUM_WIDTH-8){prev_reg[8]}}, prev_reg};
        priority if (sum_wide[SUM_WIDTH] == sum_wide[SUM_WIDTH-1])
            sum_next = sum_wide[SUM_WIDTH-1:0];
        else if (sum_wide[SUM_WIDTH])
            sum_next = SUM_MIN;
        else
            sum_next = SUM_MAX;
    end

    // power clamp and steer magnitude
    always_comb
    begin
        priority if (cfg.base_power > PWR_HI)
            power = PWR_HI;
        else if (cfg.base_power < PWR_LO)
            power = PWR_LO;
        else
            power = cfg.base_power;
        steer_neg = -steer_reg;
        steer_abs = steer_reg[7] ? steer_neg[6:0] : steer_reg[6:0];
        factor    = 7'(POWER_LIMIT) - steer_abs;
    end

    // shared multiplier operands
    always_comb
    begin
        prod_neg = -prod_reg;
        abs_val  = prod_reg[PR_W-1] ? prod_neg[13:0] : prod_reg[13:0];
        unique case (cw.mul_a)
            MA_PGAIN: a_op = {1'b0, cfg.p_gain};
            MA_DGAIN: a_op = {1'b0, cfg.d_gain};
            MA_IGAIN: a_op = {1'b0, cfg.i_gain};
            MA_POWER: a_op = {{(MA_W-8){power[7]}}, power};
            MA_RECIP: a_op = MA_W'(RECIP_100);
            default:  a_op = '0;
        endcase
        unique case (cw.mul_b)
            MB_ERR:    b_op = {{(MB_W-9){err_reg[8]}}, err_reg};
            MB_DIFF:   b_op = {{(MB_W-10){diff[9]}}, diff};
            MB_SUMLO:  b_op = {{(MB_W-LO_W){1'b0}}, sum_reg[LO_W-1:0]};
            MB_SUMHI:  b_op = {{(MB_W-HI_W){sum_reg[SUM_WIDTH-1]}},
                               sum_reg[SUM_WIDTH-1:LO_W]};
            MB_FACTOR: b_op = {{(MB_W-7){1'b0}}, factor};
            MB_ABS:    b_op = {{(MB_W-14){1'b0}}, abs_val};
            default:   b_op = '0;
        endcase
        prod_next = a_op * b_op;
    end

    // accumulator
    always_comb
    begin
        prod_ext = {{(ACC_W-PR_W){prod_reg[PR_W-1]}}, prod_reg};
        unique case (cw.acc_sh)
            SH_BYTE: addend = prod_ext <<< 8;
            SH_HALF: addend = prod_ext <<< LO_W;
            default: addend = prod_ext;
        endcase
        unique case (cw.acc_op)
            ACC_LOAD: acc_next = addend;
            ACC_ADD:  acc_next = acc_reg + addend;
            default:  acc_next = acc_reg;
        endcase
    end

    // divide by 65536 toward zero, clamp, negate
    always_comb
    begin
        acc_bias = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
        quot     = acc_bias[ACC_W-1:16];
        priority if (quot > Q_HI)
            pid = 8'(STEER_LIMIT);
        else if (quot < Q_LO)
            pid = -8'(STEER_LIMIT);
        else
            pid = quot[7:0];
        steer_next = -pid;
    end

    // side scaling and minimum rule
    always_comb
    begin
        q7        = prod_reg[RECIP_SHIFT +: 7];
        scaled    = neg_reg ? -$signed({1'b0, q7}) : $signed({1'b0, q7});
        left_raw  = steer_reg[7] ? scaled : power;
        right_raw = (!steer_reg[7] && steer_reg != 8'sd0) ? scaled : power;
        left_drv  = left_raw;
        right_drv = right_raw;
        priority if (left_raw < DRV_MIN)
            left_drv = DRV_MIN;
        else if (right_raw < DRV_MIN)
            right_drv = DRV_MIN;
    end

    assign out_full  = out_valid_reg && !out_ready;
    assign out_load  = cw.ld_out && !out_full;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cw.upd_sum)
                sum_reg <= sum_next;
            if (cw.ld_steer)
                prev_reg <= err_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            err_reg <= err_next;
        if (cw.mul_en)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (cw.ld_steer)
            steer_reg <= steer_next;
        if (cw.ld_sign)
            neg_reg <= prod_reg[PR_W-1];
        if (out_load)
            out_data_reg <= {right_drv, left_drv, steer_reg};
    end

endmodule

@@ sv/pid_line_steer_mixer_unit.sv @@
// Top level of the PID line steering mixer: stream ports, configuration registers,
// microcode sequencer and datapath. Depends on plsm_pkg, plsm_sequencer, plsm_datapath.
//
// Usage:
//   s_* carries one reflectance sample per control tick (s_tdata[7:0]).
//   m_* returns one result per sample: steer value, left and right drive.
//   cfg_* writes one of six registers (white, target, base power, P, I, D gains);
//   cfg_ready is always high; writes must wait while a sample is in flight (unchecked).
// Timing:
//   A sample is taken only at step 0 of a ten-step microprogram; the result is
//   loaded into the output register at step 9, the last step of the program.
//   A new sample is taken only once the last one has run through every step,
//   since the single shared multiplier is stepped through P, D, two I partial
//   products, side scale and divide by 100.
//   The output register holds one result; while it is still full at the last step
//   the program waits there, so a stalled receiver holds off the next sample.
// Reset:
//   rst_n clears the step counter, previous error, error sum and output valid, and
//   loads the register defaults (100, 40, 60, 640, 655, 1280).
module pid_line_steer_mixer_unit
    import plsm_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] reflect_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] steer_value, [15:8] left_drive,
                                    // [23:16] right_drive
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    ucw_t      cw;
    seq_stat_t stat;
    logic      out_full;

    assign cfg_ready     = 1'b1;
    assign s_tready      = cw.in_rdy;
    assign stat.in_fire  = s_tvalid && s_tready;
    assign stat.out_full = out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.white      <= WHITE_RST;
            cfg_reg.target     <= TARGET_RST;
            cfg_reg.base_power <= POWER_RST;
            cfg_reg.p_gain     <= PGAIN_RST;
            cfg_reg.i_gain     <= IGAIN_RST;
            cfg_reg.d_gain     <= DGAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WHITE:  cfg_reg.white      <= cfg_data[7:0];
                REG_TARGET: cfg_reg.target     <= cfg_data[7:0];
                REG_POWER:  cfg_reg.base_power <= $signed(cfg_data[7:0]);
                REG_PGAIN:  cfg_reg.p_gain     <= cfg_data;
                REG_IGAIN:  cfg_reg.i_gain     <= cfg_data;
                REG_DGAIN:  cfg_reg.d_gain     <= cfg_data;
                default:    cfg_reg            <= cfg_reg;
            endcase
        end
    end

    plsm_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cw    (cw)
    );

    plsm_datapath #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .cfg       (cfg_reg),
        .in_fire   (stat.in_fire),
        .sample    (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_full  (out_full)
    );

    // one sample at a time: ready drops right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while previous one still in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[7:0]) <= 8'sd80) && ($signed(m_tdata[7:0]) >= -8'sd80))
        else $error("steer value outside clamp range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[15:8]) >= 8'sd5)
        else $error("left drive below minimum");

endmodule
